// File: src/rbtf_pkg.sv
package rbtf_pkg;

    // Default sizes, overridable on the top level
    localparam int DEF_STORE_DEPTH = 4096;
    localparam int DEF_MAX_CHUNK   = 100;

    // Frame position counter width; holds header + largest payload + checksum
    localparam int POS_W = 8;

    // Frame constants
    localparam logic [7:0] SOF_BYTE      = 8'h7E;
    localparam logic [7:0] FRAME_ID      = 8'h01;
    localparam logic [7:0] ADDR16_HIGH   = 8'hFF;
    localparam logic [7:0] ADDR16_LOW    = 8'hFE;
    localparam logic [7:0] CSUM_BASE     = 8'hFF;
    localparam int         LEN_OVERHEAD  = 14;
    localparam int         PAYLOAD_START = 17;
    localparam int         SUM_START     = 3;

    // Register reset values
    localparam logic [7:0] FRAME_TYPE_RST  = 8'h10;
    localparam logic [6:0] CHUNK_LIMIT_RST = 7'd100;

    // Input commands
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_PULL  = 1'b1;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_DEST_HIGH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEST_LOW    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_TYPE  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_LIMIT = 2'd3;

    typedef struct packed {
        logic       command;
        logic [7:0] data;
    } t_in_item;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       frame_end;
    } t_out_item;

    // Header byte at frame position pos (positions below PAYLOAD_START)
    function automatic logic [7:0] header_byte(
        input logic [POS_W-1:0] pos,
        input logic [7:0]       len,
        input logic [7:0]       ftype,
        input logic [31:0]      dest_hi,
        input logic [31:0]      dest_lo
    );
        logic [15:0] flen;
        logic [7:0]  b;
        flen = 16'(len) + 16'(LEN_OVERHEAD);
        unique case (pos)
            8'd0:    b = SOF_BYTE;
            8'd1:    b = flen[15:8];
            8'd2:    b = flen[7:0];
            8'd3:    b = ftype;
            8'd4:    b = FRAME_ID;
            8'd5:    b = dest_hi[31:24];
            8'd6:    b = dest_hi[23:16];
            8'd7:    b = dest_hi[15:8];
            8'd8:    b = dest_hi[7:0];
            8'd9:    b = dest_lo[31:24];
            8'd10:   b = dest_lo[23:16];
            8'd11:   b = dest_lo[15:8];
            8'd12:   b = dest_lo[7:0];
            8'd13:   b = ADDR16_HIGH;
            8'd14:   b = ADDR16_LOW;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// File: src/rbtf_ram.sv
module rbtf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/ring_buffered_radio_tx_framer.sv
// Write beat: accepted with no result; the next beat may follow at once.
// Pull beat: a header or checksum byte passes FETCH and EMIT into the output register; a
// payload byte also passes PAYLD for the frame copy RAM read; the next beat waits for IDLE.
// An output stall holds EMIT. A pull with an empty store and no open frame yields nothing. A pull
// that opens a frame first passes START and COPY, copying n ring RAM bytes, one per cycle via its single read port.
// Synchronous active-low reset clears pointers, count and frame state; RAMs are not cleared.
module ring_buffered_radio_tx_framer
    import rbtf_pkg::*;
#(
    parameter int STORE_DEPTH = DEF_STORE_DEPTH,
    parameter int MAX_CHUNK   = DEF_MAX_CHUNK
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input items
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_item             i_in_item,
    // result items
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_item            o_out_item,
    // configuration writes
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data
);

    localparam int PTR_W  = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(STORE_DEPTH + 1);
    localparam int LEN_W  = $clog2(MAX_CHUNK + 1);
    localparam int CIDX_W = (MAX_CHUNK > 1) ? $clog2(MAX_CHUNK) : 1;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_START = 3'd1;
    localparam logic [2:0] S_COPY  = 3'd2;
    localparam logic [2:0] S_FETCH = 3'd3;
    localparam logic [2:0] S_PAYLD = 3'd4;
    localparam logic [2:0] S_EMIT  = 3'd5;

    // Control state
    logic [2:0]        r_state,     n_state;
    logic [PTR_W-1:0]  r_rp,        n_rp;
    logic [PTR_W-1:0]  r_wp,        n_wp;
    logic [CNT_W-1:0]  r_count,     n_count;
    logic [LEN_W-1:0]  r_len,       n_len;
    logic [POS_W-1:0]  r_pos,       n_pos;
    logic [7:0]        r_sum,       n_sum;
    logic              r_in_frame,  n_in_frame;
    logic [LEN_W-1:0]  r_rd_cnt,    n_rd_cnt;
    logic              r_wr_pend,   n_wr_pend;
    logic              r_out_valid, n_out_valid;

    // Datapath registers
    logic [PTR_W-1:0]  r_src,       n_src;
    logic [CIDX_W-1:0] r_wr_idx,    n_wr_idx;
    logic [7:0]        r_byte,      n_byte;
    logic              r_byte_end,  n_byte_end;
    t_out_item         r_out,       n_out;
    logic [31:0]       r_held_hi,   n_held_hi;
    logic [31:0]       r_held_lo,   n_held_lo;
    logic [7:0]        r_held_type, n_held_type;

    // Configuration registers
    logic [31:0]       r_dest_high;
    logic [31:0]       r_dest_low;
    logic [7:0]        r_frame_type;
    logic [6:0]        r_chunk_limit;

    logic              in_accept;
    logic              store_we;
    logic [7:0]        store_rdata;
    logic [7:0]        copy_rdata;
    logic [CIDX_W-1:0] copy_raddr;
    logic [POS_W-1:0]  pay_off;

    logic [7:0]        lim8;
    logic [CNT_W-1:0]  to_wrap;
    logic [CNT_W-1:0]  min_a;
    logic [CNT_W-1:0]  claim;
    logic [CNT_W-1:0]  rp_sum;
    logic              rd_go;
    logic              emit_go;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != S_IDLE);
    assign in_accept   = i_in_valid && !o_in_stall;
    assign store_we    = in_accept && (i_in_item.command == CMD_WRITE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // Ring store and frame copy
    rbtf_ram #(.WIDTH(8), .DEPTH(STORE_DEPTH)) u_store (
        .i_clk   (i_clk),
        .i_we    (store_we),
        .i_waddr (r_wp),
        .i_wdata (i_in_item.data),
        .i_raddr (r_src),
        .o_rdata (store_rdata)
    );

    rbtf_ram #(.WIDTH(8), .DEPTH(MAX_CHUNK)) u_copy (
        .i_clk   (i_clk),
        .i_we    (r_wr_pend),
        .i_waddr (r_wr_idx),
        .i_wdata (store_rdata),
        .i_raddr (copy_raddr),
        .o_rdata (copy_rdata)
    );

    // Chunk size for a new frame: min(count, bytes to wrap, clamped limit)
    always_comb begin
        if (r_chunk_limit == 7'd0) begin
            lim8 = 8'd1;
        end else if ({1'b0, r_chunk_limit} > 8'(MAX_CHUNK)) begin
            lim8 = 8'(MAX_CHUNK);
        end else begin
            lim8 = {1'b0, r_chunk_limit};
        end
        to_wrap = CNT_W'(STORE_DEPTH) - CNT_W'(r_rp);
        min_a   = (r_count < to_wrap) ? r_count : to_wrap;
        claim   = (min_a < CNT_W'(lim8)) ? min_a : CNT_W'(lim8);
        rp_sum  = CNT_W'(r_rp) + claim;
    end

    assign pay_off    = r_pos - POS_W'(PAYLOAD_START);
    assign copy_raddr = CIDX_W'(pay_off);
    assign rd_go      = (r_rd_cnt != r_len);
    assign emit_go    = !r_out_valid || !i_out_stall;

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_rp        = r_rp;
        n_wp        = r_wp;
        n_count     = r_count;
        n_len       = r_len;
        n_pos       = r_pos;
        n_sum       = r_sum;
        n_in_frame  = r_in_frame;
        n_rd_cnt    = r_rd_cnt;
        n_wr_pend   = 1'b0;
        n_wr_idx    = r_wr_idx;
        n_src       = r_src;
        n_byte      = r_byte;
        n_byte_end  = r_byte_end;
        n_held_hi   = r_held_hi;
        n_held_lo   = r_held_lo;
        n_held_type = r_held_type;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;

        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    if (i_in_item.command == CMD_WRITE) begin
                        // store byte, overwrite oldest when full
                        n_wp = (r_wp == PTR_W'(STORE_DEPTH - 1)) ? '0 : r_wp + 1'b1;
                        if (r_count == CNT_W'(STORE_DEPTH)) begin
                            n_rp = n_wp;
                        end else begin
                            n_count = r_count + 1'b1;
                        end
                    end else if (r_in_frame) begin
                        n_state = S_FETCH;
                    end else if (r_count != '0) begin
                        n_state = S_START;
                    end
                end
            end
            S_START: begin
                // claim the chunk and latch the header fields
                n_len       = LEN_W'(claim);
                n_count     = r_count - claim;
                n_rp        = (rp_sum == CNT_W'(STORE_DEPTH)) ? '0 : PTR_W'(rp_sum);
                n_src       = r_rp;
                n_rd_cnt    = '0;
                n_pos       = '0;
                n_sum       = '0;
                n_in_frame  = 1'b1;
                n_held_hi   = r_dest_high;
                n_held_lo   = r_dest_low;
                n_held_type = r_frame_type;
                n_state     = S_COPY;
            end
            S_COPY: begin
                // one store read per cycle, its registered data written to the copy once r_wr_pend is set
                if (rd_go) begin
                    n_src     = r_src + 1'b1;
                    n_rd_cnt  = r_rd_cnt + 1'b1;
                    n_wr_pend = 1'b1;
                    n_wr_idx  = r_rd_cnt[CIDX_W-1:0];
                end else if (!r_wr_pend) begin
                    n_state = S_FETCH;
                end
            end
            S_FETCH: begin
                if (r_pos < POS_W'(PAYLOAD_START)) begin
                    n_byte     = header_byte(r_pos, 8'(r_len), r_held_type,
                                             r_held_hi, r_held_lo);
                    n_byte_end = 1'b0;
                    n_state    = S_EMIT;
                end else if (pay_off < POS_W'(r_len)) begin
                    n_state = S_PAYLD;
                end else begin
                    n_byte     = CSUM_BASE - r_sum;
                    n_byte_end = 1'b1;
                    n_state    = S_EMIT;
                end
            end
            S_PAYLD: begin
                n_byte     = copy_rdata;
                n_byte_end = 1'b0;
                n_state    = S_EMIT;
            end
            S_EMIT: begin
                if (emit_go) begin
                    n_out.frame_byte = r_byte;
                    n_out.frame_end  = r_byte_end;
                    n_out_valid      = 1'b1;
                    n_state          = S_IDLE;
                    if (r_byte_end) begin
                        n_in_frame = 1'b0;
                        n_pos      = '0;
                    end else begin
                        n_pos = r_pos + 1'b1;
                        if (r_pos >= POS_W'(SUM_START)) begin
                            n_sum = r_sum + r_byte;
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rp        <= '0;
            r_wp        <= '0;
            r_count     <= '0;
            r_len       <= '0;
            r_pos       <= '0;
            r_sum       <= '0;
            r_in_frame  <= 1'b0;
            r_rd_cnt    <= '0;
            r_wr_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rp        <= n_rp;
            r_wp        <= n_wp;
            r_count     <= n_count;
            r_len       <= n_len;
            r_pos       <= n_pos;
            r_sum       <= n_sum;
            r_in_frame  <= n_in_frame;
            r_rd_cnt    <= n_rd_cnt;
            r_wr_pend   <= n_wr_pend;
            r_out_valid <= n_out_valid;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_src       <= n_src;
        r_wr_idx    <= n_wr_idx;
        r_byte      <= n_byte;
        r_byte_end  <= n_byte_end;
        r_out       <= n_out;
        r_held_hi   <= n_held_hi;
        r_held_lo   <= n_held_lo;
        r_held_type <= n_held_type;
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dest_high   <= '0;
            r_dest_low    <= '0;
            r_frame_type  <= FRAME_TYPE_RST;
            r_chunk_limit <= CHUNK_LIMIT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_DEST_HIGH:   r_dest_high   <= i_cfg_data;
                CFG_DEST_LOW:    r_dest_low    <= i_cfg_data;
                CFG_FRAME_TYPE:  r_frame_type  <= i_cfg_data[7:0];
                CFG_CHUNK_LIMIT: r_chunk_limit <= i_cfg_data[6:0];
                default: begin
                end
            endcase
        end
    end

    // Checks
    a_pos_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_frame |-> (r_pos == '0))
        else $error("frame position not cleared outside a frame");

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(STORE_DEPTH))
        else $error("stored count above store depth");

    a_len_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_frame |-> (r_len != '0))
        else $error("frame open with empty payload");

    a_end_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && emit_go && r_byte_end) |=> !r_in_frame)
        else $error("checksum beat did not close the frame");

    a_copy_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FETCH) |-> (!r_wr_pend && r_rd_cnt == r_len))
        else $error("frame bytes fetched before copy finished");

endmodule

// File: verif/ring_buffered_radio_tx_framer_checker.sv
module ring_buffered_radio_tx_framer_checker
    import rbtf_pkg::*;
#(
    parameter int STORE_DEPTH = DEF_STORE_DEPTH,
    parameter int MAX_CHUNK   = DEF_MAX_CHUNK
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  t_in_item             i_in_item,
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  t_out_item            i_out_item,
    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data,
    output int                   o_fail_count,
    output int                   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // register copies
    logic [31:0] dest_hi_r;
    logic [31:0] dest_lo_r;
    logic [7:0]  ftype_r;
    logic [6:0]  chunk_lim_r;

    // values latched at frame start
    logic [63:0] dest_held;
    logic [7:0]  ftype_held;

    // ring store and frame state
    logic [7:0]  ring_mem [STORE_DEPTH];
    int unsigned rd_ptr;
    int unsigned wr_ptr;
    int unsigned fill;
    logic [7:0]  payload_buf [MAX_CHUNK];
    int unsigned payload_len;
    int unsigned frame_pos;
    logic [7:0]  csum_acc;
    bit          framing;

    // frame bytes still owed by the block, oldest first
    t_out_item   owed_frame_bytes[$];

    // advance the framer by one input beat, queue the byte it yields, if any
    task automatic predict_frame_byte(input t_in_item beat);
        int unsigned n;
        int unsigned lim;
        logic [15:0] flen;
        logic [7:0]  b;
        logic        last;
        t_out_item   res;
        if (beat.command == CMD_WRITE) begin
            ring_mem[wr_ptr] = beat.data;
            wr_ptr = (wr_ptr + 1) % STORE_DEPTH;
            fill++;
            // full store: oldest byte lost, read side follows write side
            if (fill > STORE_DEPTH) begin
                fill = STORE_DEPTH;
                rd_ptr = wr_ptr;
            end
            return;
        end
        if (!framing) begin
            if (fill == 0) return;
            lim = (chunk_lim_r == 0) ? 1 :
                  ((chunk_lim_r > MAX_CHUNK) ? MAX_CHUNK : chunk_lim_r);
            n = fill;
            if (STORE_DEPTH - rd_ptr < n) n = STORE_DEPTH - rd_ptr;
            if (lim < n) n = lim;
            for (int i = 0; i < n; i++) payload_buf[i] = ring_mem[rd_ptr + i];
            fill -= n;
            rd_ptr = (rd_ptr + n) % STORE_DEPTH;
            payload_len = n;
            frame_pos = 0;
            csum_acc = 8'h00;
            dest_held = {dest_hi_r, dest_lo_r};
            ftype_held = ftype_r;
            framing = 1'b1;
        end
        last = 1'b0;
        flen = 16'(payload_len + LEN_OVERHEAD);
        if (frame_pos < PAYLOAD_START) begin
            case (frame_pos)
                0:  b = SOF_BYTE;
                1:  b = flen[15:8];
                2:  b = flen[7:0];
                3:  b = ftype_held;
                4:  b = FRAME_ID;
                13: b = ADDR16_HIGH;
                14: b = ADDR16_LOW;
                // destination MSB first, then the two zero option bytes
                default: b = (frame_pos >= 5 && frame_pos <= 12) ?
                             dest_held[8*(12-frame_pos) +: 8] : 8'h00;
            endcase
        end else if (frame_pos - PAYLOAD_START < payload_len) begin
            b = payload_buf[frame_pos - PAYLOAD_START];
        end else begin
            b = CSUM_BASE - csum_acc;
            last = 1'b1;
        end
        if (frame_pos >= SUM_START && !last) csum_acc += b;
        if (last) begin
            framing = 1'b0;
            frame_pos = 0;
        end else begin
            frame_pos++;
        end
        res.frame_byte = b;
        res.frame_end = last;
        owed_frame_bytes.push_back(res);
    endtask

    // watch all three channels at the rising edge
    always @(posedge i_clk) begin : monitor
        t_out_item want;
        if (!i_rst_n) begin
            dest_hi_r = '0;
            dest_lo_r = '0;
            ftype_r = FRAME_TYPE_RST;
            chunk_lim_r = CHUNK_LIMIT_RST;
            dest_held = '0;
            ftype_held = FRAME_TYPE_RST;
            rd_ptr = 0;
            wr_ptr = 0;
            fill = 0;
            payload_len = 0;
            frame_pos = 0;
            csum_acc = 8'h00;
            framing = 1'b0;
            owed_frame_bytes.delete();
            o_fail_count = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_DEST_HIGH:   dest_hi_r = i_cfg_data;
                    CFG_DEST_LOW:    dest_lo_r = i_cfg_data;
                    CFG_FRAME_TYPE:  ftype_r = i_cfg_data[7:0];
                    CFG_CHUNK_LIMIT: chunk_lim_r = i_cfg_data[6:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) predict_frame_byte(i_in_item);
            if (i_out_valid && !i_out_stall) begin
                if (owed_frame_bytes.size() == 0) begin
                    $error("unexpected frame beat: frame_byte 8'h%02h frame_end %0b",
                           i_out_item.frame_byte, i_out_item.frame_end);
                    o_fail_count++;
                end else begin
                    want = owed_frame_bytes.pop_front();
                    if (i_out_item.frame_byte !== want.frame_byte) begin
                        $error("frame_byte: expected 8'h%02h, actual 8'h%02h",
                               want.frame_byte, i_out_item.frame_byte);
                        o_fail_count++;
                    end
                    if (i_out_item.frame_end !== want.frame_end) begin
                        $error("frame_end: expected %0b, actual %0b",
                               want.frame_end, i_out_item.frame_end);
                        o_fail_count++;
                    end
                end
            end
        end
        o_pending = owed_frame_bytes.size();
    end

endmodule

// File: verif/ring_buffered_radio_tx_framer_tb.sv
module ring_buffered_radio_tx_framer_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import rbtf_pkg::*;

    localparam int STORE_DEPTH = DEF_STORE_DEPTH;
    localparam int MAX_CHUNK   = DEF_MAX_CHUNK;
    localparam int QUIET_CYCLES = 150;
    localparam int STUCK_LIMIT  = 2000;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    t_in_item             in_item = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    t_out_item            out_item;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0]          cfg_data = '0;
    int                   fail_count;
    int                   pending;

    int          send_idle_pct = 0;
    int          stall_pct = 0;
    int unsigned beats_sent = 0;
    int unsigned writes_total = 0;
    logic [6:0]  chunk_cur = CHUNK_LIMIT_RST;
    int          stuck_cycles = 0;

    ring_buffered_radio_tx_framer #(
        .STORE_DEPTH(STORE_DEPTH),
        .MAX_CHUNK  (MAX_CHUNK)
    ) u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_item  (in_item),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_item (out_item),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index),
        .i_cfg_data (cfg_data)
    );

    ring_buffered_radio_tx_framer_checker #(
        .STORE_DEPTH(STORE_DEPTH),
        .MAX_CHUNK  (MAX_CHUNK)
    ) u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_in_item   (in_item),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_out_item  (out_item),
        .i_cfg_valid (cfg_valid),
        .i_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    // 8 ns clock
    initial begin
        forever #4 clk = ~clk;
    end

    // random receiver back-pressure
    initial begin
        forever begin
            @(negedge clk);
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // give up when no channel moves a beat for too long
    initial begin
        while (stuck_cycles < STUCK_LIMIT) begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                (cfg_valid && cfg_ready))
                stuck_cycles = 0;
            else
                stuck_cycles++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    // one input beat, with random idle cycles ahead of it
    task automatic send_beat(input logic cmd, input logic [7:0] dat);
        t_in_item beat;
        beat.command = cmd;
        beat.data = dat;
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item <= beat;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        beats_sent++;
        if (cmd == CMD_WRITE) writes_total++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // drain all owed bytes, then let the block finish any frame-start copy
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        wait (pending == 0);
        repeat (QUIET_CYCLES) @(posedge clk);
    endtask

    // unused upper data bits carry noise
    task automatic program_regs(input logic [31:0] dh, input logic [31:0] dl,
                                input logic [7:0] ft, input logic [6:0] cl);
        settle();
        write_reg(CFG_DEST_HIGH, dh);
        write_reg(CFG_DEST_LOW, dl);
        write_reg(CFG_FRAME_TYPE, {24'($urandom), ft});
        write_reg(CFG_CHUNK_LIMIT, {25'($urandom), cl});
        chunk_cur = cl;
    endtask

    task automatic set_idle_mode(input int mode);
        case (mode)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 53; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 53; end
            default: begin send_idle_pct = 17; stall_pct = 17; end
        endcase
    endtask

    initial begin
        int unsigned target;
        int unsigned eff;
        int unsigned k;
        int unsigned frames;
        int unsigned pulls;
        int unsigned d;
        int unsigned m;
        int          r;
        logic [6:0]  cl;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: pull on empty store, then one full frame at reset settings
        send_beat(CMD_PULL, 8'hFF);
        send_beat(CMD_WRITE, 8'h00);
        send_beat(CMD_WRITE, 8'hFF);
        send_beat(CMD_WRITE, 8'hA5);
        repeat (21) send_beat(CMD_PULL, 8'($urandom));

        // random phases; the first four walk the register extremes
        for (int ph = 0; ph < 12; ph++) begin
            case (ph)
                0: program_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 7'd0);
                1: program_regs(32'h0000_0000, 32'h0000_0000, 8'h00, 7'd127);
                2: program_regs($urandom, $urandom, FRAME_TYPE_RST, 7'd1);
                3: program_regs($urandom, $urandom, 8'($urandom), 7'(MAX_CHUNK));
                default: begin
                    r = $urandom_range(99);
                    if (r < 80) cl = 7'($urandom_range(1, 12));
                    else if (r < 85) cl = 7'd0;
                    else if (r < 90) cl = 7'(MAX_CHUNK + 1);
                    else cl = 7'($urandom);
                    program_regs($urandom, $urandom, 8'($urandom), cl);
                end
            endcase
            set_idle_mode(ph % 4);
            eff = (chunk_cur == 0) ? 1 : ((chunk_cur > MAX_CHUNK) ? MAX_CHUNK : chunk_cur);
            target = beats_sent + 130;
            while (beats_sent < target) begin
                r = $urandom_range(99);
                if (r < 75) begin
                    // burst of writes followed by roughly enough pulls to ship it
                    k = $urandom_range(1, (2 * eff < 24) ? 2 * eff : 24);
                    repeat (k) send_beat(CMD_WRITE, 8'($urandom));
                    frames = (k + eff - 1) / eff;
                    pulls = k + 18 * frames + $urandom_range(0, 3);
                    pulls = pulls - $urandom_range(0, 3);
                    repeat (pulls) send_beat(CMD_PULL, 8'($urandom));
                end else if (r < 90) begin
                    repeat (8) send_beat(1'($urandom), 8'($urandom));
                end else if (r < 95) begin
                    repeat ($urandom_range(1, 6)) send_beat(CMD_PULL, 8'($urandom));
                end else begin
                    repeat ($urandom_range(1, 6)) send_beat(CMD_WRITE, 8'($urandom));
                end
            end
        end

        // overflow the store so the write pointer lands just short of the wrap
        program_regs($urandom, $urandom, 8'($urandom), 7'(MAX_CHUNK));
        set_idle_mode(0);
        d = $urandom_range(1, 60);
        m = STORE_DEPTH + 1;
        m += (STORE_DEPTH - d + 2 * STORE_DEPTH - (writes_total + m) % STORE_DEPTH)
             % STORE_DEPTH;
        repeat (m) send_beat(CMD_WRITE, 8'($urandom));
        // first frame is cut at the wrap, the next ones run full size
        set_idle_mode(3);
        repeat (d + 18 + 2 * (MAX_CHUNK + 18) + $urandom_range(0, 30))
            send_beat(CMD_PULL, 8'($urandom));

        settle();
        if (fail_count == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// File: files.f
src/rbtf_pkg.sv
src/rbtf_ram.sv
src/ring_buffered_radio_tx_framer.sv
verif/ring_buffered_radio_tx_framer_checker.sv
verif/ring_buffered_radio_tx_framer_tb.sv
